@@ rtl/itys_pkg.sv @@
package itys_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_TABLE_LEN  = 24;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_CENTER   = 3'd0;
    localparam logic [2:0] REG_SPAN     = 3'd1;
    localparam logic [2:0] REG_FLOOR    = 3'd2;
    localparam logic [2:0] REG_CEILING  = 3'd3;
    localparam logic [2:0] REG_DEADBAND = 3'd4;

    localparam logic [11:0] CENTER_RST   = 12'd1500;
    localparam logic [11:0] SPAN_RST     = 12'd900;
    localparam logic [11:0] FLOOR_RST    = 12'd544;
    localparam logic [11:0] CEILING_RST  = 12'd2400;
    localparam logic [14:0] DEADBAND_RST = 15'd13;

    // Width of the CORDIC angle and datapath registers.
    localparam int ANG_W = 34;
    localparam int XY_W  = 30;

    // Quarter turn in angle units.
    localparam logic signed [ANG_W-1:0] QUARTER = 34'sd1073741824;

    // Yaw units per quarter turn.
    localparam logic [30:0] YAW_PER_QUARTER = 31'd1440000000;

    // Configuration values handed to the datapath.
    typedef struct packed {
        logic [11:0] center;
        logic [11:0] span;
        logic [11:0] floor_v;
        logic [11:0] ceiling;
    } pulse_cfg_t;

    // Elementary angle atan(2^-i) in units of 2^-30 quarter turn.
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        begin
            case (i)
                5'd0:  r = 34'sd536870912;
                5'd1:  r = 34'sd316933406;
                5'd2:  r = 34'sd167458907;
                5'd3:  r = 34'sd85004756;
                5'd4:  r = 34'sd42667331;
                5'd5:  r = 34'sd21354465;
                5'd6:  r = 34'sd10679838;
                5'd7:  r = 34'sd5340245;
                5'd8:  r = 34'sd2670163;
                5'd9:  r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Clamp a wide signed pulse to the configured window.
    function automatic logic [11:0] clamp_pulse(input logic signed [31:0] p,
                                                input pulse_cfg_t c);
        logic [11:0] r;
        begin
            if (p < $signed({20'd0, c.floor_v}))
                r = c.floor_v;
            else if (p > $signed({20'd0, c.ceiling}))
                r = c.ceiling;
            else
                r = p[11:0];
            return r;
        end
    endfunction

endpackage

@@ rtl/imu_tilt_yaw_to_servo_pulse.sv @@
// IMU tilt and yaw to servo pulse converter.
// Input channel s_axis: one transaction carries one IMU sample (accelerometer
// X, Y, Z, gyro Z rate and elapsed microseconds). Output channel m_axis: one
// transaction carries the three clamped pulse widths for pitch, roll and yaw.
// The configuration port writes pulse center, span, floor, ceiling and the
// gyro deadband; write it only while the block is idle.
// Items are handled one at a time. An accepted sample passes through the
// serial square root, two passes of the shared CORDIC (pitch, then roll),
// three passes of the shared serial scaler (each with a start, a multiply
// and a divide phase) and the output load state.
// A zero accelerometer vector ends a CORDIC pass without micro-rotations.
// The serial units set the throughput: a new sample is taken only after the
// previous result has been taken by the receiver.
// s_axis_tready is high only when no item is in work and the output
// register is empty, so a stalled receiver holds the result and the input.
// Reset clears the yaw accumulator, loads the default registers and
// empties the output register.
module imu_tilt_yaw_to_servo_pulse
#(
    parameter int CORDIC_STEPS = itys_pkg::CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x, accel_y, accel_z, rate_z, elapsed_us, zero fill
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pitch_pulse, roll_pulse, yaw_pulse, zero fill
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_PITCH, ST_ROLL, ST_SPITCH, ST_SROLL, ST_SYAW, ST_OUT
    } state_t;

    state_t             state_reg;
    itys_pkg::pulse_cfg_t cfg_reg;
    logic [14:0]        deadband_reg;
    logic signed [47:0] yaw_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [33:0] pitch_reg, roll_reg;
    logic [11:0]        pp_reg, rp_reg;
    logic [39:0]        out_reg;
    logic               ovalid_reg;

    logic signed [15:0] in_ax, in_ay, in_az, in_rate;
    logic [19:0]        in_dt;
    logic               in_acc;
    logic [47:0]        sq_in;
    logic               sq_done, co_start, co_done, sc_start, sc_done;
    logic [23:0]        sq_root;
    logic signed [29:0] co_y, co_x;
    logic signed [33:0] co_ang;
    logic signed [47:0] sc_val;
    logic [30:0]        sc_div;
    logic signed [31:0] sc_q, pulse_sum;
    logic [15:0]        rate_mag;
    logic signed [36:0] rate_dt;
    logic signed [48:0] yaw_sum;
    logic signed [47:0] yaw_sat;

    assign in_ax   = s_axis_tdata[15:0];
    assign in_ay   = s_axis_tdata[31:16];
    assign in_az   = s_axis_tdata[47:32];
    assign in_rate = s_axis_tdata[63:48];
    assign in_dt   = s_axis_tdata[83:64];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    // Sum of squares shifted up by 16 bits for the pitch denominator.
    assign sq_in = {32'(32'(in_ay * in_ay) + 32'(in_az * in_az)), 16'd0};

    // Yaw integration with saturation at the accumulator width.
    assign rate_mag = in_rate[15] ? 16'(-in_rate) : in_rate;
    assign rate_dt  = 37'(in_rate) * $signed({17'd0, in_dt});
    assign yaw_sum  = 49'(yaw_reg) + 49'(rate_dt);
    assign yaw_sat  = (yaw_sum[48] != yaw_sum[47]) ?
                      (yaw_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) :
                      yaw_sum[47:0];

    itys_isqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    // The CORDIC is shared between pitch and roll.
    assign co_start = sq_done || (co_done && state_reg == ST_PITCH);
    assign co_y = (state_reg == ST_SQRT) ? 30'($signed({ax_reg, 8'd0})) :
                                           30'($signed({ay_reg, 8'd0}));
    assign co_x = (state_reg == ST_SQRT) ? $signed({6'd0, sq_root}) :
                                           30'($signed({az_reg, 8'd0}));

    itys_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (co_start),
        .y_in  (co_y),
        .x_in  (co_x),
        .done  (co_done),
        .angle (co_ang)
    );

    // The scaler is shared by the three pulse offsets.
    always_comb
    begin
        sc_start = 1'b0;
        sc_val   = 48'(pitch_reg);
        sc_div   = 31'(itys_pkg::QUARTER);
        case (state_reg)
            ST_ROLL:   sc_start = co_done;
            ST_SPITCH:
            begin
                sc_val   = 48'(roll_reg);
                sc_start = sc_done;
            end
            ST_SROLL:
            begin
                sc_val   = yaw_reg;
                sc_div   = itys_pkg::YAW_PER_QUARTER;
                sc_start = sc_done;
            end
            default: sc_start = 1'b0;
        endcase
    end

    itys_scale u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sc_start),
        .value    (sc_val),
        .span     (cfg_reg.span),
        .divisor  (sc_div),
        .done     (sc_done),
        .quotient (sc_q)
    );

    assign pulse_sum = $signed({20'd0, cfg_reg.center}) + sc_q;

    // Sequencer, registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ovalid_reg      <= 1'b0;
            yaw_reg         <= '0;
            pitch_reg       <= '0;
            roll_reg        <= '0;
            pp_reg          <= '0;
            rp_reg          <= '0;
            out_reg         <= '0;
            cfg_reg.center  <= itys_pkg::CENTER_RST;
            cfg_reg.span    <= itys_pkg::SPAN_RST;
            cfg_reg.floor_v <= itys_pkg::FLOOR_RST;
            cfg_reg.ceiling <= itys_pkg::CEILING_RST;
            deadband_reg    <= itys_pkg::DEADBAND_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    itys_pkg::REG_CENTER:   cfg_reg.center  <= cfg_data[11:0];
                    itys_pkg::REG_SPAN:     cfg_reg.span    <= cfg_data[11:0];
                    itys_pkg::REG_FLOOR:    cfg_reg.floor_v <= cfg_data[11:0];
                    itys_pkg::REG_CEILING:  cfg_reg.ceiling <= cfg_data[11:0];
                    itys_pkg::REG_DEADBAND: deadband_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (in_acc)
                    begin
                        if (rate_mag > {1'b0, deadband_reg})
                            yaw_reg <= yaw_sat;
                        state_reg <= ST_SQRT;
                    end
                ST_SQRT:   if (sq_done) state_reg <= ST_PITCH;
                ST_PITCH:
                    if (co_done)
                    begin
                        pitch_reg <= co_ang;
                        state_reg <= ST_ROLL;
                    end
                ST_ROLL:
                    if (co_done)
                    begin
                        roll_reg  <= co_ang;
                        state_reg <= ST_SPITCH;
                    end
                ST_SPITCH:
                    if (sc_done)
                    begin
                        pp_reg    <= itys_pkg::clamp_pulse(pulse_sum, cfg_reg);
                        state_reg <= ST_SROLL;
                    end
                ST_SROLL:
                    if (sc_done)
                    begin
                        rp_reg    <= itys_pkg::clamp_pulse(pulse_sum, cfg_reg);
                        state_reg <= ST_SYAW;
                    end
                ST_SYAW:
                    if (sc_done)
                    begin
                        out_reg <= {4'd0, itys_pkg::clamp_pulse(pulse_sum, cfg_reg),
                                    rp_reg, pp_reg};
                        state_reg <= ST_OUT;
                    end
                ST_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ax_reg <= in_ax;
            ay_reg <= in_ay;
            az_reg <= in_az;
        end
    end

    // No new sample is taken while a result is waiting.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");

    // An accepted sample always starts the square root next cycle.
    a_start_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == ST_SQRT)
        else $error("sequencer missed a sample");

    // The output valid flag rises only from the final state.
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("unexpected result");

endmodule

@@ rtl/itys_isqrt.sv @@
// Bit-serial integer square root, two radicand bits per cycle.
module itys_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] radicand,
    output logic        done,
    output logic [23:0] root
);

    logic [47:0] rem_reg, rem_next;
    logic [23:0] root_reg, root_next;
    logic [47:0] src_reg, src_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [49:0] trial;
    logic [47:0] shifted;

    // One restoring step per cycle on the next two radicand bits.
    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        src_next  = src_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[45:0], src_reg[47:46]};
        trial     = {2'b0, shifted} - {24'd0, root_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            root_next = '0;
            src_next  = radicand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            src_next = {src_reg[45:0], 2'b00};
            if (!trial[49])
            begin
                rem_next  = trial[47:0];
                root_next = {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        src_reg  <= src_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/itys_cordic.sv @@
// Iterative vectoring CORDIC, one micro-rotation per cycle.
module itys_cordic
#(
    parameter int CORDIC_STEPS = itys_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [itys_pkg::XY_W-1:0]    y_in,
    input  logic signed [itys_pkg::XY_W-1:0]    x_in,
    output logic                                done,
    output logic signed [itys_pkg::ANG_W-1:0]   angle
);

    localparam int STEPS = (CORDIC_STEPS > itys_pkg::ANGLE_TABLE_LEN) ?
                           itys_pkg::ANGLE_TABLE_LEN : CORDIC_STEPS;
    localparam int XW = itys_pkg::XY_W + 2;

    logic signed [XW-1:0]             x_reg, x_next, y_reg, y_next;
    logic signed [itys_pkg::ANG_W-1:0] z_reg, z_next;
    logic [4:0]                       i_reg, i_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic signed [XW-1:0]             xs, ys, xi, yi;

    // Pre-rotation into the right half plane, then one step a cycle.
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xi        = XW'(x_in);
        yi        = XW'(y_in);
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        if (start)
        begin
            i_next = '0;
            z_next = '0;
            x_next = xi;
            y_next = yi;
            if (x_in == '0 && y_in == '0)
                done_next = 1'b1;
            else
            begin
                busy_next = 1'b1;
                if (x_in < 0)
                begin
                    if (y_in >= 0)
                    begin
                        x_next = yi;
                        y_next = -xi;
                        z_next = itys_pkg::QUARTER;
                    end
                    else
                    begin
                        x_next = -yi;
                        y_next = xi;
                        z_next = -itys_pkg::QUARTER;
                    end
                end
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + itys_pkg::atan_step(i_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - itys_pkg::atan_step(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

@@ rtl/itys_scale.sv @@
// Serial shift-add scaler: computes trunc(value * span / divisor) by
// multiplying one span bit per cycle, then a restoring divide one bit per cycle.
module itys_scale
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [47:0] value,
    input  logic [11:0]        span,
    input  logic [30:0]        divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_t;

    state_t      state_reg, state_next;
    logic [59:0] prod_reg, prod_next;
    logic [47:0] mag_reg, mag_next;
    logic [11:0] span_reg, span_next;
    logic [30:0] div_reg, div_next;
    logic [31:0] rem_reg, rem_next;
    logic [30:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [31:0] rsh;
    logic [32:0] diff;
    logic signed [31:0] sq;

    // Product is at most 2^59; with divisors of at least 2^30 the quotient
    // stays below 2^29, so a 31-bit quotient register holds it whole.
    always_comb
    begin
        state_next = state_reg;
        prod_next  = prod_reg;
        mag_next   = mag_reg;
        span_next  = span_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        rsh        = {rem_reg[30:0], prod_reg[59]};
        diff       = {1'b0, rsh} - {2'b0, div_reg};
        sq         = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    neg_next   = value[47];
                    mag_next   = value[47] ? 48'(-value) : value;
                    span_next  = span;
                    div_next   = divisor;
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next = {prod_reg[58:0], 1'b0} +
                            (span_reg[11] ? {12'd0, mag_reg} : 60'd0);
                span_next = {span_reg[10:0], 1'b0};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd11)
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    quo_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                prod_next = {prod_reg[58:0], 1'b0};
                if (!diff[32])
                begin
                    rem_next = diff[31:0];
                    quo_next = {quo_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next = rsh;
                    quo_next = {quo_reg[29:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd59)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        quotient = sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        mag_reg  <= mag_next;
        span_reg <= span_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        neg_reg  <= neg_next;
    end

    assign done = done_reg;

endmodule
